/* hdl/assert_macros.svh */
// Assertion macros shared by the parser RTL.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that a condition implies another on the same edge.
`define ASSERT_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (prop)) else $error(msg);

`endif

/* hdl/mtep_pkg.sv */
// Shared types and constants for the MIDI track event parser.
// No dependencies; used by every module of the parser.
package mtep_pkg;

    localparam int MAX_LENGTH_BYTES = 4;
    localparam int LEN_CNT_W        = 3;
    localparam int VLQ_W            = 28;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    localparam logic [7:0] STATUS_META    = 8'hFF;
    localparam logic [7:0] STATUS_SYSEX   = 8'hF0;
    localparam logic [7:0] STATUS_ESCAPE  = 8'hF7;
    localparam logic [7:0] META_END_TRACK = 8'h2F;
    localparam logic [3:0] NIBBLE_PROGRAM = 4'hC;
    localparam logic [3:0] NIBBLE_CHPRESS = 4'hD;
    localparam logic [3:0] NIBBLE_NOTEOFF = 4'h8;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_NO_RUN   = 2'd1;
    localparam logic [1:0] ERR_UNKNOWN  = 2'd2;
    localparam logic [1:0] ERR_OVERLONG = 2'd3;

    typedef enum logic [3:0] {
        KIND_NOTEOFF   = 4'd0,
        KIND_NOTEON    = 4'd1,
        KIND_POLYPRESS = 4'd2,
        KIND_CONTROL   = 4'd3,
        KIND_PROGRAM   = 4'd4,
        KIND_CHPRESS   = 4'd5,
        KIND_PITCH     = 4'd6,
        KIND_META      = 4'd7,
        KIND_SYSEX     = 4'd8,
        KIND_PAYLOAD   = 4'd9,
        KIND_END       = 4'd10,
        KIND_ERROR     = 4'd11
    } t_kind;

    typedef enum logic [6:0] {
        PH_DELTA   = 7'b0000001,
        PH_STATUS  = 7'b0000010,
        PH_DATA1   = 7'b0000100,
        PH_DATA2   = 7'b0001000,
        PH_MTYPE   = 7'b0010000,
        PH_LENGTH  = 7'b0100000,
        PH_PAYLOAD = 7'b1000000
    } t_phase;

    // One classified track word as it travels through the queue.
    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       is_data;
        logic       is_chan;
        logic       is_meta;
        logic       is_sysex;
    } t_word;

    typedef struct packed {
        t_kind              kind;
        logic [VLQ_W-1:0]   delta_time;
        logic [3:0]         channel;
        logic [7:0]         first_data;
        logic [13:0]        second_data;
        logic [VLQ_W-1:0]   payload_length;
        logic               last_payload;
        logic [1:0]         error_code;
    } t_result;

endpackage

/* hdl/midi_track_event_parser.sv */
// MIDI track event parser: one track body word in, at most one event result out per word.
// The parser sustains one word per clock while the output is not held stalled. An accepted
// word is classified and written to a two-entry queue; the event state machine takes it
// whenever the result register is free or being drained and registers its result, if any,
// as it takes the word; the result is held in that register until taken downstream.
// The input stalls only when the queue is full, which happens when the output is held
// stalled; the result register frees as soon as its word is taken downstream.
// Depends on mtep_pkg, mtep_front, mtep_queue, mtep_back and assert_macros.svh.
`include "assert_macros.svh"

module midi_track_event_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_track_byte,
    input  logic        i_track_start,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_kind,
    output logic [27:0] o_delta_time,
    output logic [3:0]  o_channel,
    output logic [7:0]  o_first_data,
    output logic [13:0] o_second_data,
    output logic [27:0] o_payload_length,
    output logic        o_last_payload,
    output logic [1:0]  o_error_code
);

    logic              q_full;
    logic              q_push;
    logic              q_pop;
    logic              q_valid;
    mtep_pkg::t_word   front_word;
    mtep_pkg::t_word   head_word;
    mtep_pkg::t_result result;

    mtep_front u_front (
        .i_valid       (i_in_valid),
        .i_track_byte  (i_track_byte),
        .i_track_start (i_track_start),
        .i_full        (q_full),
        .o_stall       (o_in_stall),
        .o_push        (q_push),
        .o_word        (front_word)
    );

    mtep_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_word  (front_word),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_word  (head_word)
    );

    mtep_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_word  (head_word),
        .o_pop     (q_pop),
        .i_stall   (i_out_stall),
        .o_valid   (o_out_valid),
        .o_result  (result)
    );

    assign o_kind           = 4'(result.kind);
    assign o_delta_time     = result.delta_time;
    assign o_channel        = result.channel;
    assign o_first_data     = result.first_data;
    assign o_second_data    = result.second_data;
    assign o_payload_length = result.payload_length;
    assign o_last_payload   = result.last_payload;
    assign o_error_code     = result.error_code;

    `ASSERT_CLK(a_err_code_kind,
        !o_out_valid || ((o_kind == 4'(mtep_pkg::KIND_ERROR)) ==
            (o_error_code != mtep_pkg::ERR_NONE)),
        "error code and error kind disagree")
    `ASSERT_IMPLY(a_last_on_payload, o_out_valid && o_last_payload,
        o_kind == 4'(mtep_pkg::KIND_PAYLOAD), "last flag on a non-payload result")
    `ASSERT_IMPLY(a_no_pop_while_held, o_out_valid && i_out_stall, !q_pop,
        "word taken while the result is held")

endmodule

/* hdl/mtep_front.sv */
// Front end of the parser: takes track words and tags each with its byte class.
// Depends on mtep_pkg; feeds mtep_queue.
module mtep_front (
    input  logic           i_valid,
    input  logic [7:0]     i_track_byte,
    input  logic           i_track_start,
    input  logic           i_full,
    output logic           o_stall,
    output logic           o_push,
    output mtep_pkg::t_word o_word
);

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_word          = '0;
        o_word.data     = i_track_byte;
        o_word.start    = i_track_start;
        o_word.is_data  = !i_track_byte[7];
        o_word.is_chan  = i_track_byte[7] && (i_track_byte[6:4] != 3'b111);
        o_word.is_meta  = (i_track_byte == mtep_pkg::STATUS_META);
        o_word.is_sysex = (i_track_byte == mtep_pkg::STATUS_SYSEX) ||
                          (i_track_byte == mtep_pkg::STATUS_ESCAPE);
    end

endmodule

/* hdl/mtep_queue.sv */
// Short word queue between the classifying front end and the parser back end.
// Depends on mtep_pkg.
module mtep_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mtep_pkg::t_word i_word,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output mtep_pkg::t_word o_word
);

    mtep_pkg::t_word                      r_mem [mtep_pkg::QUEUE_DEPTH];
    logic [mtep_pkg::QUEUE_PTR_W-1:0]     r_wr_ptr;
    logic [mtep_pkg::QUEUE_PTR_W-1:0]     r_rd_ptr;
    logic [mtep_pkg::QUEUE_CNT_W-1:0]     r_count;
    logic [mtep_pkg::QUEUE_PTR_W-1:0]     n_wr_ptr;
    logic [mtep_pkg::QUEUE_PTR_W-1:0]     n_rd_ptr;
    logic [mtep_pkg::QUEUE_CNT_W-1:0]     n_count;

    localparam logic [mtep_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
        mtep_pkg::QUEUE_PTR_W'(mtep_pkg::QUEUE_DEPTH - 1);
    localparam logic [mtep_pkg::QUEUE_CNT_W-1:0] FULL_CNT =
        mtep_pkg::QUEUE_CNT_W'(mtep_pkg::QUEUE_DEPTH);

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

endmodule

/* hdl/mtep_back.sv */
// Back end of the parser: event state machine and the result register.
// Depends on mtep_pkg; consumes words from mtep_queue.
module mtep_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  mtep_pkg::t_word   i_q_word,
    output logic              o_pop,
    input  logic              i_stall,
    output logic              o_valid,
    output mtep_pkg::t_result o_result
);

    localparam int W = mtep_pkg::VLQ_W;
    localparam int C = mtep_pkg::LEN_CNT_W;

    mtep_pkg::t_phase   r_phase, n_phase, e_phase;
    logic [7:0]         r_running, n_running, e_running;
    logic [7:0]         r_current, n_current, e_current;
    logic [W-1:0]       r_acc, n_acc, e_acc;
    logic [C-1:0]       r_cnt, n_cnt, e_cnt;
    logic [W-1:0]       r_delta, n_delta, e_delta;
    logic [7:0]         r_first, n_first, e_first;
    logic [W-1:0]       r_remain, n_remain, e_remain;
    logic               r_ended, n_ended, e_ended;

    logic               r_out_valid;
    mtep_pkg::t_result  r_res;
    mtep_pkg::t_result  res;
    logic               produce;

    logic [7:0]         b;
    logic [W-1:0]       acc_step;
    logic [C-1:0]       cnt_step;
    logic               vlq_done;
    logic               vlq_over;
    logic               end_meta;
    logic               last;

    function automatic mtep_pkg::t_result err_result(input logic [1:0] code);
        mtep_pkg::t_result r;
        r            = '0;
        r.kind       = mtep_pkg::KIND_ERROR;
        r.error_code = code;
        return r;
    endfunction

    function automatic logic one_data(input logic [7:0] st);
        return (st[7:4] == mtep_pkg::NIBBLE_PROGRAM) ||
               (st[7:4] == mtep_pkg::NIBBLE_CHPRESS);
    endfunction

    function automatic mtep_pkg::t_result chan_result(
        input logic [7:0] st, input logic [W-1:0] dt,
        input logic [7:0] d1, input logic [7:0] d2);
        mtep_pkg::t_result r;
        r            = '0;
        r.kind       = mtep_pkg::t_kind'(st[7:4] - mtep_pkg::NIBBLE_NOTEOFF);
        r.delta_time = dt;
        r.channel    = st[3:0];
        r.first_data = d1;
        if (r.kind == mtep_pkg::KIND_PITCH) begin
            r.second_data = {d2[6:0], d1[6:0]};
        end else begin
            r.second_data = {6'd0, d2};
        end
        return r;
    endfunction

    // Take a word whenever the result register is free or being drained.
    assign o_pop    = i_q_valid && (!r_out_valid || !i_stall);
    assign o_valid  = r_out_valid;
    assign o_result = r_res;

    always_comb begin
        // A track start clears the parser before this word is parsed.
        if (i_q_word.start) begin
            e_phase   = mtep_pkg::PH_DELTA;
            e_running = '0;
            e_current = '0;
            e_acc     = '0;
            e_cnt     = '0;
            e_delta   = '0;
            e_first   = '0;
            e_remain  = '0;
            e_ended   = 1'b0;
        end else begin
            e_phase   = r_phase;
            e_running = r_running;
            e_current = r_current;
            e_acc     = r_acc;
            e_cnt     = r_cnt;
            e_delta   = r_delta;
            e_first   = r_first;
            e_remain  = r_remain;
            e_ended   = r_ended;
        end

        n_phase   = e_phase;
        n_running = e_running;
        n_current = e_current;
        n_acc     = e_acc;
        n_cnt     = e_cnt;
        n_delta   = e_delta;
        n_first   = e_first;
        n_remain  = e_remain;
        n_ended   = e_ended;
        produce   = 1'b0;
        res       = '0;

        b        = i_q_word.data;
        acc_step = {e_acc[W-8:0], b[6:0]};
        cnt_step = e_cnt + 1'b1;
        vlq_done = !b[7];
        vlq_over = b[7] && (cnt_step >= C'(mtep_pkg::MAX_LENGTH_BYTES));
        end_meta = (e_current == mtep_pkg::STATUS_META) &&
                   (e_first == mtep_pkg::META_END_TRACK);
        last     = (e_remain <= W'(1));

        if (!e_ended) begin
            case (e_phase)
                mtep_pkg::PH_DELTA: begin
                    if (vlq_over) begin
                        res     = err_result(mtep_pkg::ERR_OVERLONG);
                        produce = 1'b1;
                        n_phase = mtep_pkg::PH_DELTA;
                        n_acc   = '0;
                        n_cnt   = '0;
                    end else if (vlq_done) begin
                        n_delta = acc_step;
                        n_acc   = '0;
                        n_cnt   = '0;
                        n_phase = mtep_pkg::PH_STATUS;
                    end else begin
                        n_acc = acc_step;
                        n_cnt = cnt_step;
                    end
                end
                mtep_pkg::PH_STATUS: begin
                    if (i_q_word.is_data) begin
                        if (e_running == '0) begin
                            res     = err_result(mtep_pkg::ERR_NO_RUN);
                            produce = 1'b1;
                            n_phase = mtep_pkg::PH_DELTA;
                            n_acc   = '0;
                            n_cnt   = '0;
                        end else begin
                            n_current = e_running;
                            if (one_data(e_running)) begin
                                res     = chan_result(e_running, e_delta, b, 8'd0);
                                produce = 1'b1;
                                n_phase = mtep_pkg::PH_DELTA;
                            end else begin
                                n_first = b;
                                n_phase = mtep_pkg::PH_DATA2;
                            end
                        end
                    end else if (i_q_word.is_chan) begin
                        n_running = b;
                        n_current = b;
                        n_phase   = mtep_pkg::PH_DATA1;
                    end else begin
                        // Only channel messages keep running status.
                        n_running = '0;
                        if (i_q_word.is_meta) begin
                            n_current = b;
                            n_phase   = mtep_pkg::PH_MTYPE;
                        end else if (i_q_word.is_sysex) begin
                            n_current = b;
                            n_first   = '0;
                            n_acc     = '0;
                            n_cnt     = '0;
                            n_phase   = mtep_pkg::PH_LENGTH;
                        end else begin
                            res     = err_result(mtep_pkg::ERR_UNKNOWN);
                            produce = 1'b1;
                            n_phase = mtep_pkg::PH_DELTA;
                            n_acc   = '0;
                            n_cnt   = '0;
                        end
                    end
                end
                mtep_pkg::PH_DATA1: begin
                    if (one_data(e_current)) begin
                        res     = chan_result(e_current, e_delta, b, 8'd0);
                        produce = 1'b1;
                        n_phase = mtep_pkg::PH_DELTA;
                    end else begin
                        n_first = b;
                        n_phase = mtep_pkg::PH_DATA2;
                    end
                end
                mtep_pkg::PH_DATA2: begin
                    res     = chan_result(e_current, e_delta, e_first, b);
                    produce = 1'b1;
                    n_phase = mtep_pkg::PH_DELTA;
                end
                mtep_pkg::PH_MTYPE: begin
                    n_first = b;
                    n_acc   = '0;
                    n_cnt   = '0;
                    n_phase = mtep_pkg::PH_LENGTH;
                end
                mtep_pkg::PH_LENGTH: begin
                    if (vlq_over) begin
                        res     = err_result(mtep_pkg::ERR_OVERLONG);
                        produce = 1'b1;
                        n_phase = mtep_pkg::PH_DELTA;
                        n_acc   = '0;
                        n_cnt   = '0;
                    end else if (!vlq_done) begin
                        n_acc = acc_step;
                        n_cnt = cnt_step;
                    end else begin
                        res = '0;
                        if (e_current != mtep_pkg::STATUS_META) begin
                            res.kind = mtep_pkg::KIND_SYSEX;
                        end else if (end_meta) begin
                            res.kind = mtep_pkg::KIND_END;
                        end else begin
                            res.kind = mtep_pkg::KIND_META;
                        end
                        res.delta_time     = e_delta;
                        res.first_data     = e_first;
                        res.payload_length = acc_step;
                        produce            = 1'b1;
                        n_remain           = acc_step;
                        if (acc_step == '0) begin
                            n_phase = mtep_pkg::PH_DELTA;
                            n_ended = end_meta;
                            n_acc   = '0;
                            n_cnt   = '0;
                        end else begin
                            // Hold the length for the payload words.
                            n_acc   = acc_step;
                            n_cnt   = cnt_step;
                            n_phase = mtep_pkg::PH_PAYLOAD;
                        end
                    end
                end
                mtep_pkg::PH_PAYLOAD: begin
                    res                = '0;
                    res.kind           = mtep_pkg::KIND_PAYLOAD;
                    res.delta_time     = e_delta;
                    res.first_data     = b;
                    res.payload_length = e_acc;
                    res.last_payload   = last;
                    produce            = 1'b1;
                    n_remain           = last ? '0 : e_remain - 1'b1;
                    if (last) begin
                        n_phase = mtep_pkg::PH_DELTA;
                        n_ended = end_meta;
                        n_acc   = '0;
                        n_cnt   = '0;
                    end
                end
                default: begin
                    n_phase = mtep_pkg::PH_DELTA;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= mtep_pkg::PH_DELTA;
            r_running   <= '0;
            r_current   <= '0;
            r_acc       <= '0;
            r_cnt       <= '0;
            r_delta     <= '0;
            r_first     <= '0;
            r_remain    <= '0;
            r_ended     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase     <= n_phase;
                r_running   <= n_running;
                r_current   <= n_current;
                r_acc       <= n_acc;
                r_cnt       <= n_cnt;
                r_delta     <= n_delta;
                r_first     <= n_first;
                r_remain    <= n_remain;
                r_ended     <= n_ended;
                r_out_valid <= produce;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && produce) begin
            r_res <= res;
        end
    end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for midi_track_event_parser: directed table, then random track streams.
// Depends on mtep_pkg and the parser RTL; a parser model predicts events of untyped words.
module tb;

    typedef struct {
        logic [7:0]        b;
        logic              start;
        bit                typed;
        mtep_pkg::t_result res;
    } t_row;

    localparam int RANDOM_WORDS = 550;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  in_byte = 8'd0;
    logic        in_start = 1'b0;
    logic        out_stall = 1'b0;
    bit          in_typed = 1'b0;
    mtep_pkg::t_result in_res = '0;
    bit          drain = 1'b0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic [3:0]  o_kind;
    logic [27:0] o_delta_time;
    logic [3:0]  o_channel;
    logic [7:0]  o_first_data;
    logic [13:0] o_second_data;
    logic [27:0] o_payload_length;
    logic        o_last_payload;
    logic [1:0]  o_error_code;

    // model state
    mtep_pkg::t_phase ph;
    logic [7:0]  run_status;
    logic [7:0]  cur_status;
    logic [27:0] vlq_acc;
    logic [2:0]  vlq_cnt;
    logic [27:0] ev_delta;
    logic [7:0]  ev_first;
    logic [27:0] bytes_left;
    logic        track_done;

    t_row              stim[$];
    mtep_pkg::t_result pending_events[$];

    int n_directed = 0;
    int n_ignored = 0;
    int n_results = 0;
    int n_err_events = 0;
    int n_end_events = 0;
    int mismatches = 0;
    bit gen_rs = 1'b0;
    bit gen_need_start = 1'b1;
    logic [7:0] gen_last_chan = 8'h90;

    midi_track_event_parser uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (o_in_stall),
        .i_track_byte     (in_byte),
        .i_track_start    (in_start),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (out_stall),
        .o_kind           (o_kind),
        .o_delta_time     (o_delta_time),
        .o_channel        (o_channel),
        .o_first_data     (o_first_data),
        .o_second_data    (o_second_data),
        .o_payload_length (o_payload_length),
        .o_last_payload   (o_last_payload),
        .o_error_code     (o_error_code)
    );

    always #4 i_clk = ~i_clk;

    // ---------------- parser model ----------------

    function automatic void clear_parser();
        ph = mtep_pkg::PH_DELTA;
        run_status = 8'd0;
        cur_status = 8'd0;
        vlq_acc = 28'd0;
        vlq_cnt = 3'd0;
        ev_delta = 28'd0;
        ev_first = 8'd0;
        bytes_left = 28'd0;
        track_done = 1'b0;
    endfunction

    function automatic bit single_data(input logic [7:0] st);
        return st[7:4] == mtep_pkg::NIBBLE_PROGRAM || st[7:4] == mtep_pkg::NIBBLE_CHPRESS;
    endfunction

    // Shift in one variable-length byte: 1 done, 0 more to come, -1 too long.
    function automatic int vlq_add(input logic [7:0] b);
        vlq_acc = {vlq_acc[20:0], b[6:0]};
        vlq_cnt = vlq_cnt + 3'd1;
        if (!b[7])
            return 1;
        if (vlq_cnt >= mtep_pkg::MAX_LENGTH_BYTES)
            return -1;
        return 0;
    endfunction

    function automatic mtep_pkg::t_result flag_error(input logic [1:0] code);
        mtep_pkg::t_result r = '0;
        r.kind = mtep_pkg::KIND_ERROR;
        r.error_code = code;
        ph = mtep_pkg::PH_DELTA;
        vlq_acc = 28'd0;
        vlq_cnt = 3'd0;
        return r;
    endfunction

    function automatic mtep_pkg::t_result chan_event(input logic [7:0] d1,
                                                     input logic [7:0] d2);
        mtep_pkg::t_result r = '0;
        r.kind = mtep_pkg::t_kind'(cur_status[7:4] - mtep_pkg::NIBBLE_NOTEOFF);
        r.delta_time = ev_delta;
        r.channel = cur_status[3:0];
        r.first_data = d1;
        if (r.kind == mtep_pkg::KIND_PITCH)
            r.second_data = {d2[6:0], d1[6:0]};
        else
            r.second_data = {6'd0, d2};
        ph = mtep_pkg::PH_DELTA;
        return r;
    endfunction

    function automatic bit parse_word(input logic [7:0] b, input logic start,
                                      output mtep_pkg::t_result r);
        int step;
        bit is_end;
        r = '0;
        if (start)
            clear_parser();
        if (track_done)
            return 0;
        is_end = cur_status == mtep_pkg::STATUS_META && ev_first == mtep_pkg::META_END_TRACK;
        case (ph)
            mtep_pkg::PH_DELTA: begin
                step = vlq_add(b);
                if (step < 0) begin
                    r = flag_error(mtep_pkg::ERR_OVERLONG);
                    return 1;
                end
                if (step > 0) begin
                    ev_delta = vlq_acc;
                    vlq_acc = 28'd0;
                    vlq_cnt = 3'd0;
                    ph = mtep_pkg::PH_STATUS;
                end
                return 0;
            end
            mtep_pkg::PH_STATUS: begin
                if (!b[7]) begin
                    if (run_status == 8'd0) begin
                        r = flag_error(mtep_pkg::ERR_NO_RUN);
                        return 1;
                    end
                    cur_status = run_status;
                    if (single_data(cur_status)) begin
                        r = chan_event(b, 8'd0);
                        return 1;
                    end
                    ev_first = b;
                    ph = mtep_pkg::PH_DATA2;
                    return 0;
                end
                if (b < 8'hF0) begin
                    run_status = b;
                    cur_status = b;
                    ph = mtep_pkg::PH_DATA1;
                    return 0;
                end
                run_status = 8'd0;
                if (b == mtep_pkg::STATUS_META) begin
                    cur_status = b;
                    ph = mtep_pkg::PH_MTYPE;
                    return 0;
                end
                if (b == mtep_pkg::STATUS_SYSEX || b == mtep_pkg::STATUS_ESCAPE) begin
                    cur_status = b;
                    ev_first = 8'd0;
                    vlq_acc = 28'd0;
                    vlq_cnt = 3'd0;
                    ph = mtep_pkg::PH_LENGTH;
                    return 0;
                end
                r = flag_error(mtep_pkg::ERR_UNKNOWN);
                return 1;
            end
            mtep_pkg::PH_DATA1: begin
                if (single_data(cur_status)) begin
                    r = chan_event(b, 8'd0);
                    return 1;
                end
                ev_first = b;
                ph = mtep_pkg::PH_DATA2;
                return 0;
            end
            mtep_pkg::PH_DATA2: begin
                r = chan_event(ev_first, b);
                return 1;
            end
            mtep_pkg::PH_MTYPE: begin
                ev_first = b;
                vlq_acc = 28'd0;
                vlq_cnt = 3'd0;
                ph = mtep_pkg::PH_LENGTH;
                return 0;
            end
            mtep_pkg::PH_LENGTH: begin
                step = vlq_add(b);
                if (step < 0) begin
                    r = flag_error(mtep_pkg::ERR_OVERLONG);
                    return 1;
                end
                if (step == 0)
                    return 0;
                is_end = cur_status == mtep_pkg::STATUS_META &&
                         ev_first == mtep_pkg::META_END_TRACK;
                if (cur_status != mtep_pkg::STATUS_META)
                    r.kind = mtep_pkg::KIND_SYSEX;
                else if (is_end)
                    r.kind = mtep_pkg::KIND_END;
                else
                    r.kind = mtep_pkg::KIND_META;
                r.delta_time = ev_delta;
                r.first_data = ev_first;
                r.payload_length = vlq_acc;
                bytes_left = vlq_acc;
                if (bytes_left == 28'd0) begin
                    ph = mtep_pkg::PH_DELTA;
                    track_done = is_end;
                    vlq_acc = 28'd0;
                    vlq_cnt = 3'd0;
                end else begin
                    ph = mtep_pkg::PH_PAYLOAD;
                end
                return 1;
            end
            mtep_pkg::PH_PAYLOAD: begin
                r.kind = mtep_pkg::KIND_PAYLOAD;
                r.delta_time = ev_delta;
                r.first_data = b;
                r.payload_length = vlq_acc;
                r.last_payload = bytes_left <= 28'd1;
                if (r.last_payload) begin
                    bytes_left = 28'd0;
                    ph = mtep_pkg::PH_DELTA;
                    track_done = is_end;
                    vlq_acc = 28'd0;
                    vlq_cnt = 3'd0;
                end else begin
                    bytes_left = bytes_left - 28'd1;
                end
                return 1;
            end
            default: begin
                ph = mtep_pkg::PH_DELTA;
                return 0;
            end
        endcase
    endfunction

    // ---------------- stimulus ----------------

    function automatic mtep_pkg::t_result mk(input mtep_pkg::t_kind kind,
                                             input logic [27:0] dt,
                                             input logic [3:0] ch, input logic [7:0] d1,
                                             input logic [13:0] d2, input logic [27:0] len,
                                             input logic last, input logic [1:0] err);
        mtep_pkg::t_result r;
        r.kind = kind;
        r.delta_time = dt;
        r.channel = ch;
        r.first_data = d1;
        r.second_data = d2;
        r.payload_length = len;
        r.last_payload = last;
        r.error_code = err;
        return r;
    endfunction

    function automatic void add_word(input logic [7:0] b, input logic start);
        t_row row;
        row.b = b;
        row.start = start;
        row.typed = 1'b0;
        row.res = '0;
        stim.insert(stim.size(), row);
    endfunction

    function automatic void add_typed(input logic [7:0] b, input mtep_pkg::t_result res);
        t_row row;
        row.b = b;
        row.start = 1'b0;
        row.typed = 1'b1;
        row.res = res;
        stim.insert(stim.size(), row);
    endfunction

    function automatic void load_directed();
        add_word(8'h00, 1'b1);
        add_typed(8'h45, mk(mtep_pkg::KIND_ERROR, 0, 0, 0, 0, 0, 0, mtep_pkg::ERR_NO_RUN));
        // largest delta time, then a two-byte sysex
        add_word(8'hFF, 1'b0);
        add_word(8'hFF, 1'b0);
        add_word(8'hFF, 1'b0);
        add_word(8'h7F, 1'b0);
        add_word(mtep_pkg::STATUS_SYSEX, 1'b0);
        add_typed(8'h02, mk(mtep_pkg::KIND_SYSEX, 28'hFFFFFFF, 0, 0, 0, 2, 0,
                            mtep_pkg::ERR_NONE));
        add_word(8'hFF, 1'b0);
        add_word(8'h00, 1'b0);
        add_word(8'h00, 1'b0);
        add_typed(8'hF1, mk(mtep_pkg::KIND_ERROR, 0, 0, 0, 0, 0, 0, mtep_pkg::ERR_UNKNOWN));
        add_word(8'h80, 1'b0);
        add_word(8'h80, 1'b0);
        add_word(8'h80, 1'b0);
        add_typed(8'h80, mk(mtep_pkg::KIND_ERROR, 0, 0, 0, 0, 0, 0, mtep_pkg::ERR_OVERLONG));
        // pitch wheel with status bytes in data positions
        add_word(8'h00, 1'b0);
        add_word(8'hEF, 1'b0);
        add_word(8'hFF, 1'b0);
        add_typed(8'hFF, mk(mtep_pkg::KIND_PITCH, 0, 4'hF, 8'hFF, 14'h3FFF, 0, 0,
                            mtep_pkg::ERR_NONE));
        add_word(8'h05, 1'b0);
        add_word(8'h7F, 1'b0);
        add_word(8'h00, 1'b0);
        add_word(8'h00, 1'b0);
        add_word(8'hC3, 1'b0);
        add_word(8'h80, 1'b0);
        add_word(8'h00, 1'b0);
        add_word(mtep_pkg::STATUS_META, 1'b0);
        add_word(mtep_pkg::META_END_TRACK, 1'b0);
        add_typed(8'h00, mk(mtep_pkg::KIND_END, 0, 0, mtep_pkg::META_END_TRACK, 0, 0, 0,
                            mtep_pkg::ERR_NONE));
        add_word(8'h12, 1'b0);
    endfunction

    function automatic logic [7:0] rand_data();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(128, 255));
        return 8'($urandom_range(0, 127));
    endfunction

    function automatic void gen_delta();
        int n;
        logic [31:0] v;
        logic st;
        st = gen_need_start || $urandom_range(0, 32) == 0;
        if (st)
            gen_rs = 1'b0;
        gen_need_start = 1'b0;
        n = ($urandom_range(0, 9) < 7) ? 1 : $urandom_range(2, 4);
        v = $urandom;
        for (int i = n - 1; i >= 0; i--) begin
            add_word({i != 0, v[7*i +: 7]}, st);
            st = 1'b0;
        end
    endfunction

    function automatic void gen_length(input int len);
        int pad;
        pad = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
        repeat (pad) add_word(8'h80, 1'b0);
        add_word(len[7:0], 1'b0);
    endfunction

    function automatic logic [7:0] rand_unknown();
        logic [7:0] st;
        st = 8'($urandom_range(8'hF1, 8'hFE));
        if (st == mtep_pkg::STATUS_ESCAPE)
            st = 8'hF8;
        return st;
    endfunction

    function automatic void gen_event();
        int pick, len;
        logic [7:0] st, mtype;
        pick = $urandom_range(0, 99);
        if (pick >= 94 && pick < 97 && !gen_need_start) begin
            // delta time that never terminates
            repeat (mtep_pkg::MAX_LENGTH_BYTES)
                add_word(8'h80 | 8'($urandom_range(0, 127)), 1'b0);
            return;
        end
        gen_delta();
        if (pick < 45 || pick >= 97) begin
            st = 8'($urandom_range(8'h80, 8'hEF));
            add_word(st, 1'b0);
            add_word(rand_data(), 1'b0);
            if (!single_data(st))
                add_word(rand_data(), 1'b0);
            gen_rs = 1'b1;
            gen_last_chan = st;
        end else if (pick < 63) begin
            add_word(8'($urandom_range(0, 127)), 1'b0);
            if (gen_rs && !single_data(gen_last_chan))
                add_word(rand_data(), 1'b0);
        end else if (pick < 81) begin
            if (pick < 73) begin
                mtype = ($urandom_range(0, 9) == 0) ? mtep_pkg::META_END_TRACK
                                                     : 8'($urandom_range(0, 255));
                add_word(mtep_pkg::STATUS_META, 1'b0);
                add_word(mtype, 1'b0);
            end else begin
                mtype = 8'd0;
                add_word($urandom_range(0, 1) ? mtep_pkg::STATUS_SYSEX
                                              : mtep_pkg::STATUS_ESCAPE, 1'b0);
            end
            len = $urandom_range(0, 6);
            gen_length(len);
            repeat (len) add_word(8'($urandom_range(0, 255)), 1'b0);
            gen_rs = 1'b0;
            if (pick < 73 && mtype == mtep_pkg::META_END_TRACK) begin
                // trailing words are dropped until the next track start
                len = $urandom_range(0, 4);
                repeat (len) add_word(8'($urandom_range(0, 255)), 1'b0);
                n_ignored += len;
                gen_need_start = 1'b1;
            end
        end else if (pick < 85) begin
            add_word(rand_unknown(), 1'b0);
            gen_rs = 1'b0;
        end else if (pick < 88) begin
            if ($urandom_range(0, 1)) begin
                add_word(mtep_pkg::STATUS_META, 1'b0);
                add_word(8'($urandom_range(0, 255)), 1'b0);
            end else begin
                add_word(mtep_pkg::STATUS_SYSEX, 1'b0);
            end
            repeat (mtep_pkg::MAX_LENGTH_BYTES)
                add_word(8'h80 | 8'($urandom_range(0, 127)), 1'b0);
            gen_rs = 1'b0;
        end else if (pick < 91) begin
            add_word(rand_unknown(), 1'b0);
            gen_rs = 1'b0;
            gen_delta();
            add_word(8'($urandom_range(0, 127)), 1'b0);
        end else begin
            len = $urandom_range(1, 3);
            repeat (len) begin
                st = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 7) == 0) begin
                    add_word(st, 1'b1);
                    gen_rs = 1'b0;
                end else begin
                    add_word(st, 1'b0);
                end
            end
        end
    endfunction

    function automatic string show(input mtep_pkg::t_result r);
        return $sformatf("kind %0d dt %07h ch %0d d1 %02h d2 %04h len %07h last %0b err %0d",
                         r.kind, r.delta_time, r.channel, r.first_data, r.second_data,
                         r.payload_length, r.last_payload, r.error_code);
    endfunction

    // ---------------- receiver stall pattern ----------------

    int  stall_mode = 0;
    int  mode_left = 0;
    int  run_left = 0;
    bit  hold_val = 1'b0;

    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(40, 120);
        end
        mode_left--;
        if (run_left == 0) begin
            hold_val = ~hold_val;
            run_left = $urandom_range(1, 12);
        end
        run_left--;
        if (drain)
            out_stall = 1'b0;
        else
            case (stall_mode)
                0: out_stall = 1'b0;
                1: out_stall = $urandom_range(0, 3) == 0;
                2: out_stall = hold_val;
                default: out_stall = ~out_stall;
            endcase
    end

    // ---------------- checker and model update ----------------

    always @(posedge i_clk) begin
        mtep_pkg::t_result got, want, pred;
        bit has;
        if (i_rst_n) begin
            if (o_out_valid && !out_stall) begin
                got.kind = mtep_pkg::t_kind'(o_kind);
                got.delta_time = o_delta_time;
                got.channel = o_channel;
                got.first_data = o_first_data;
                got.second_data = o_second_data;
                got.payload_length = o_payload_length;
                got.last_payload = o_last_payload;
                got.error_code = o_error_code;
                n_results++;
                if (got.kind == mtep_pkg::KIND_ERROR)
                    n_err_events++;
                if (got.kind == mtep_pkg::KIND_END)
                    n_end_events++;
                if (pending_events.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected event at %0t: %s", $realtime, show(got));
                end else begin
                    want = pending_events.pop_front();
                    if (want.kind != got.kind || want.delta_time != got.delta_time ||
                        want.channel != got.channel || want.first_data != got.first_data ||
                        want.second_data != got.second_data ||
                        want.payload_length != got.payload_length ||
                        want.last_payload != got.last_payload ||
                        want.error_code != got.error_code) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("event mismatch at %0t", $realtime);
                            $display("  expected %s", show(want));
                            $display("  actual   %s", show(got));
                        end
                    end
                end
            end
            if (in_valid && !o_in_stall) begin
                has = parse_word(in_byte, in_start, pred);
                if (in_typed)
                    pending_events.insert(pending_events.size(), in_res);
                else if (has)
                    pending_events.insert(pending_events.size(), pred);
            end
        end
    end

    // ---------------- sender and end of run ----------------

    initial begin
        int burst_left;
        int gap;
        int guard;
        burst_left = 0;
        clear_parser();
        load_directed();
        n_directed = stim.size();
        while (stim.size() - n_ignored < n_directed + RANDOM_WORDS)
            gen_event();

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int k = 0; k < stim.size(); k++) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap != 0) begin
                    in_valid = 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
                burst_left = $urandom_range(1, 40);
            end
            burst_left--;
            in_valid = 1'b1;
            in_byte = stim[k].b;
            in_start = stim[k].start;
            in_typed = stim[k].typed;
            in_res = stim[k].res;
            // hold the word until it is taken
            do @(posedge i_clk); while (o_in_stall);
            @(negedge i_clk);
        end
        in_valid = 1'b0;
        in_typed = 1'b0;
        drain = 1'b1;

        guard = 0;
        while (pending_events.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
        if (pending_events.size() != 0) begin
            $display("%0d expected events never arrived", pending_events.size());
            mismatches += pending_events.size();
        end

        $display("Sent %0d track words (%0d directed) in random bursts against output stalls;",
                 stim.size(), n_directed);
        $display("checked %0d events, among them %0d error reports and %0d track ends.",
                 n_results, n_err_events, n_end_events);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
